FILE: rtl/core/led_strip_effect_engine_assert.svh
// Assertion macros shared by the LED strip effect engine modules.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef LED_STRIP_EFFECT_ENGINE_ASSERT_SVH
`define LED_STRIP_EFFECT_ENGINE_ASSERT_SVH

// Checked only while reset is released.
`define LSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define LSE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/lse_pkg.sv
// Package of the LED strip effect engine: codes, control structs and arithmetic helpers.
// Used by the controller, the datapath and the top level; depends on nothing.
package lse_pkg;

  localparam int NumLedsDefault = 50;
  localparam int LedIdxW        = 6;
  localparam int ChanW          = 8;
  localparam int StepW          = 7;
  localparam int BriW           = 7;
  localparam int NumerW         = 15;

  localparam int StepMax     = 100;
  localparam int RainSpan    = 8;
  localparam int PhaseStride = StepMax / RainSpan;
  localparam int BriMax      = 100;
  localparam int Recip100    = 5243;

  typedef enum logic [2:0] {
    MODE_RAINBOW = 3'd0,
    MODE_STATIC  = 3'd1,
    MODE_CLOSE   = 3'd2,
    MODE_FADE    = 3'd3,
    MODE_BLINK   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ONOFF = 2'd1,
    OP_LEVEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_OFF    = 2'd0,
    CMD_ON     = 2'd1,
    CMD_TOGGLE = 2'd2
  } cmd_e;

  // Endpoint codes; on/off commands and level commands share them.
  localparam logic [2:0] EP_POWER         = 3'd0;
  localparam logic [2:0] EP_BREATH_RED    = 3'd1;
  localparam logic [2:0] EP_BLINK_GREEN   = 3'd2;
  localparam logic [2:0] EP_RAINBOW_BLUE  = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic apply;
    logic start;
    logic issue;
  } lse_cmd_t;

  typedef struct packed {
    logic emits;
    logic last_issue;
    logic pipe_empty;
    logic adv;
  } lse_sts_t;

  // Exact floor(x / 100) for x below 25600, by reciprocal multiplication.
  function automatic logic [ChanW-1:0] div100(input logic [NumerW-1:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'(Recip100);
    return prod[26:19];
  endfunction

  function automatic logic apply_onoff(input logic flag, input logic [1:0] cmd);
    logic res;
    case (cmd)
      CMD_OFF:    res = 1'b0;
      CMD_ON:     res = 1'b1;
      CMD_TOGGLE: res = ~flag;
      default:    res = flag;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/lse_controller.sv
// Controller of the LED strip effect engine: input handshake and frame sequencing.
// Depends on lse_pkg and drives the datapath through lse_cmd_t and lse_sts_t.
`include "led_strip_effect_engine_assert.svh"

module lse_controller
  import lse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  lse_sts_t   sts_i,
  output lse_cmd_t   cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && operation_i == OP_TICK && sts_i.emits) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.adv && sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.apply = in_valid_i && (operation_i == OP_ONOFF || operation_i == OP_LEVEL);
        cmd_o.start = in_valid_i && operation_i == OP_TICK && sts_i.emits;
      end
      ST_RUN: begin
        cmd_o.issue = sts_i.adv;
      end
      ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  `LSE_ASSERT(a_ctl_idle_empty, (state_q == ST_IDLE) |-> sts_i.pipe_empty, "Idle with a busy pipeline")
  `LSE_ASSERT(a_ctl_issue_adv, cmd_o.issue |-> sts_i.adv, "LED issued into a stalled pipeline")
  `LSE_ASSERT_ALWAYS(a_ctl_cmd_excl, $onehot0({cmd_o.apply, cmd_o.start, cmd_o.issue}), "Conflicting datapath commands")

endmodule

FILE: rtl/core/lse_datapath.sv
// Datapath of the LED strip effect engine: mode state, hue phase and the color pipeline.
// Depends on lse_pkg; sequenced by lse_controller.
`include "led_strip_effect_engine_assert.svh"

module lse_datapath
  import lse_pkg::*;
#(
  parameter int NumLeds = NumLedsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         operation_i,
  input  logic [2:0]         endpoint_i,
  input  logic [1:0]         command_i,
  input  logic [7:0]         level_i,
  input  lse_cmd_t           cmd_i,
  output lse_sts_t           sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [LedIdxW-1:0] led_index_o,
  output logic [ChanW-1:0]   red_o,
  output logic [ChanW-1:0]   green_o,
  output logic [ChanW-1:0]   blue_o,
  output logic               last_o
);

  logic on_q, on_d, breath_q, breath_d, blink_q, blink_d, rainbow_q, rainbow_d;
  mode_e mode_q, mode_d;
  logic [StepW-1:0] step_q, step_d;
  logic [BriW-1:0]  bri_q, bri_d, lat_bri_q, lat_bri_d;
  logic [23:0]      static_q, static_d, lat_raw_q, lat_raw_d;

  logic [StepW-1:0]   p_q, p_d, p0;
  logic [StepW:0]     p_sum;
  logic [LedIdxW-1:0] idx_q, idx_d;

  logic adv;

  logic               a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  logic [LedIdxW-1:0] a_idx_q, b_idx_q, c_idx_q, d_idx_q;
  logic               a_last_q, b_last_q, c_last_q, d_last_q;
  logic               a_rain_q;
  logic [NumerW-1:0]  a_xr_q, a_xg_q, a_xb_q, c_pr_q, c_pg_q, c_pb_q;
  logic [BriW-1:0]    a_fac_q, b_fac_q;
  logic [ChanW-1:0]   b_r_q, b_g_q, b_b_q, d_r_q, d_g_q, d_b_q;

  logic [NumerW-1:0] xr, xg, xb;
  logic [BriW-1:0]   fac;
  logic [16:0]       m765, m738;

  // Mode state and command decoding.
  always_comb begin
    on_d      = on_q;
    breath_d  = breath_q;
    blink_d   = blink_q;
    rainbow_d = rainbow_q;
    mode_d    = mode_q;
    bri_d     = bri_q;
    static_d  = static_q;
    lat_raw_d = lat_raw_q;
    lat_bri_d = lat_bri_q;
    step_d    = step_q;
    if (cmd_i.apply) begin
      if (operation_i == OP_ONOFF) begin
        unique case (endpoint_i)
          EP_POWER:        on_d      = apply_onoff(on_q, command_i);
          EP_BREATH_RED:   breath_d  = apply_onoff(breath_q, command_i);
          EP_BLINK_GREEN:  blink_d   = apply_onoff(blink_q, command_i);
          EP_RAINBOW_BLUE: rainbow_d = apply_onoff(rainbow_q, command_i);
          default: ;
        endcase
      end else begin
        unique case (endpoint_i)
          EP_POWER:        bri_d = (level_i > 8'(BriMax)) ? BriW'(BriMax) : level_i[BriW-1:0];
          EP_BREATH_RED:   static_d[23:16] = level_i;
          EP_BLINK_GREEN:  static_d[15:8]  = level_i;
          EP_RAINBOW_BLUE: static_d[7:0]   = level_i;
          default: ;
        endcase
      end
      if (!on_d) begin
        mode_d = MODE_CLOSE;
      end else if (breath_d) begin
        mode_d = MODE_FADE;
      end else if (blink_d) begin
        mode_d = MODE_BLINK;
      end else if (rainbow_d) begin
        mode_d = MODE_RAINBOW;
      end else begin
        mode_d    = MODE_STATIC;
        lat_raw_d = static_d;
        lat_bri_d = bri_d;
      end
    end
    if (cmd_i.start && mode_q == MODE_RAINBOW) begin
      step_d = (step_q == StepW'(StepMax)) ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q      <= 1'b0;
      breath_q  <= 1'b0;
      blink_q   <= 1'b0;
      rainbow_q <= 1'b0;
      mode_q    <= MODE_RAINBOW;
      step_q    <= '0;
      bri_q     <= BriW'(BriMax);
      static_q  <= '0;
      lat_raw_q <= '0;
      lat_bri_q <= BriW'(BriMax);
    end else begin
      on_q      <= on_d;
      breath_q  <= breath_d;
      blink_q   <= blink_d;
      rainbow_q <= rainbow_d;
      mode_q    <= mode_d;
      step_q    <= step_d;
      bri_q     <= bri_d;
      static_q  <= static_d;
      lat_raw_q <= lat_raw_d;
      lat_bri_q <= lat_bri_d;
    end
  end

  // Hue position of each LED, stepped by the LED spacing modulo the wheel length.
  assign p0    = (step_q == '0 || step_q == StepW'(StepMax)) ? '0 : StepW'(StepMax) - step_q;
  assign p_sum = {1'b0, p_q} + (StepW + 1)'(PhaseStride);

  always_comb begin
    p_d   = p_q;
    idx_d = idx_q;
    if (cmd_i.start) begin
      p_d   = p0;
      idx_d = '0;
    end else if (cmd_i.issue) begin
      p_d   = (p_sum >= (StepW + 1)'(StepMax)) ? StepW'(p_sum - (StepW + 1)'(StepMax))
                                               : p_sum[StepW-1:0];
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q   <= '0;
      idx_q <= '0;
    end else begin
      p_q   <= p_d;
      idx_q <= idx_d;
    end
  end

  // Unscaled numerators of the three hue segments; static passes the latched raw colors, other modes pass zero.
  assign m765 = 17'(p_q) * 17'd765;
  assign m738 = 17'(p_q) * 17'd738;

  always_comb begin
    xr  = '0;
    xg  = '0;
    xb  = '0;
    fac = lat_bri_q;
    case (mode_q)
      MODE_RAINBOW: begin
        fac = bri_q;
        if (p_q <= StepW'(33)) begin
          xr = NumerW'(17'd25500 - m765);
          xg = NumerW'(m738);
        end else if (p_q <= StepW'(66)) begin
          xg = NumerW'(17'd49200 - m738);
          xb = NumerW'(m765 - 17'd26010);
        end else begin
          xb = NumerW'(17'd76500 - m765);
          xr = NumerW'(m765 - 17'd51255);
        end
      end
      MODE_STATIC: begin
        xr = NumerW'(lat_raw_q[23:16]);
        xg = NumerW'(lat_raw_q[15:8]);
        xb = NumerW'(lat_raw_q[7:0]);
      end
      default: ;
    endcase
  end

  assign adv = !d_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= cmd_i.issue;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_idx_q  <= idx_q;
      a_last_q <= (idx_q == LedIdxW'(NumLeds - 1));
      a_rain_q <= (mode_q == MODE_RAINBOW);
      a_xr_q   <= xr;
      a_xg_q   <= xg;
      a_xb_q   <= xb;
      a_fac_q  <= fac;

      b_idx_q  <= a_idx_q;
      b_last_q <= a_last_q;
      b_r_q    <= a_rain_q ? div100(a_xr_q) : a_xr_q[ChanW-1:0];
      b_g_q    <= a_rain_q ? div100(a_xg_q) : a_xg_q[ChanW-1:0];
      b_b_q    <= a_rain_q ? div100(a_xb_q) : a_xb_q[ChanW-1:0];
      b_fac_q  <= a_fac_q;

      c_idx_q  <= b_idx_q;
      c_last_q <= b_last_q;
      c_pr_q   <= NumerW'(b_r_q) * NumerW'(b_fac_q);
      c_pg_q   <= NumerW'(b_g_q) * NumerW'(b_fac_q);
      c_pb_q   <= NumerW'(b_b_q) * NumerW'(b_fac_q);

      d_idx_q  <= c_idx_q;
      d_last_q <= c_last_q;
      d_r_q    <= div100(c_pr_q);
      d_g_q    <= div100(c_pg_q);
      d_b_q    <= div100(c_pb_q);
    end
  end

  assign sts_o.emits      = (mode_q == MODE_RAINBOW) || (mode_q == MODE_STATIC) ||
                            (mode_q == MODE_CLOSE);
  assign sts_o.last_issue = (idx_q == LedIdxW'(NumLeds - 1));
  assign sts_o.pipe_empty = !(a_valid_q || b_valid_q || c_valid_q || d_valid_q);
  assign sts_o.adv        = adv;

  assign out_valid_o = d_valid_q;
  assign led_index_o = d_idx_q;
  assign red_o       = d_r_q;
  assign green_o     = d_g_q;
  assign blue_o      = d_b_q;
  assign last_o      = d_last_q;

  `LSE_ASSERT(a_dp_hue_range, p_q < StepW'(StepMax), "Hue position left the wheel")
  `LSE_ASSERT(a_dp_step_range, step_q <= StepW'(StepMax), "Phase step out of range")
  `LSE_ASSERT(a_dp_last_index, (d_valid_q && d_last_q) |-> (d_idx_q == LedIdxW'(NumLeds - 1)), "Last flag on a wrong LED")

endmodule

FILE: rtl/core/led_strip_effect_engine.sv
// LED strip effect engine. A tick transaction makes one color per LED of the strip,
// NumLeds transactions in index order, in rainbow, static and close modes, and none in
// fade and blink modes; on/off and level transactions change the mode state and emit
// nothing. One LED leaves the color pipeline per cycle while the output is ready. After a
// tick is accepted, the controller issues the NumLeds LEDs in turn, then waits while the
// color pipeline, whose last stage is the output register, drains, and then returns to
// idle, where the input is ready again; an output stall holds both the issue and the drain.
// Command transactions and ticks in fade and blink modes are accepted in idle, and the
// controller stays in idle for them.
// Depends on lse_pkg, lse_controller and lse_datapath.
module led_strip_effect_engine
  import lse_pkg::*;
#(
  parameter int NumLeds = NumLedsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [2:0]         endpoint_i,
  input  logic [1:0]         command_i,
  input  logic [7:0]         level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LedIdxW-1:0] led_index_o,
  output logic [ChanW-1:0]   red_o,
  output logic [ChanW-1:0]   green_o,
  output logic [ChanW-1:0]   blue_o,
  output logic               last_o
);

  lse_cmd_t cmd;
  lse_sts_t sts;

  lse_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lse_datapath #(
    .NumLeds (NumLeds)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_i),
    .endpoint_i  (endpoint_i),
    .command_i   (command_i),
    .level_i     (level_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .led_index_o (led_index_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_o      (last_o)
  );

endmodule
